FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the list engine controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PLE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define PLE_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies another in the next cycle.
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/ple_pkg.sv
// Package with constants, codes and types of the positional list engine.
`default_nettype none
package ple_pkg;
	localparam int CAPACITY   = 64;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);

	localparam int MODE_W   = 3;
	localparam int POS_W    = 7;
	localparam int VAL_W    = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;

	// Width wide enough to compare position against count + 1.
	localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd1;
	localparam logic [MODE_W-1:0] MODE_GET    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SET    = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

	typedef logic [2:0] ple_op_t;
	localparam ple_op_t CELL_HOLD = 3'd0;
	localparam ple_op_t CELL_INS  = 3'd1;
	localparam ple_op_t CELL_REM  = 3'd2;
	localparam ple_op_t CELL_SET  = 3'd3;
	localparam ple_op_t CELL_GET  = 3'd4;

	// Command broadcast to every cell of the row.
	typedef struct packed {
		ple_op_t               op;
		logic [IDX_W-1:0]      p0;
		logic [DATA_WIDTH-1:0] data;
	} ple_cmd_t;

	// Result fields produced by the controller.
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [CNT_W-1:0]    count;
		logic                empty;
	} ple_info_t;
endpackage
`default_nettype wire

FILE: hw/rtl/ple_cmd_if.sv
// Command channel interface of the list engine.
`default_nettype none
interface ple_cmd_if;
	import ple_pkg::*;
	logic                valid;
	logic                ready;
	logic [MODE_W-1:0]   mode;
	logic [POS_W-1:0]    position;
	logic [VAL_W-1:0]    value;
	modport source (output valid, output mode, output position, output value, input ready);
	modport sink (input valid, input mode, input position, input value, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/ple_res_if.sv
// Result channel interface of the list engine.
`default_nettype none
interface ple_res_if;
	import ple_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [VAL_W-1:0]    read_value;
	logic [COUNT_W-1:0]  count;
	logic                empty_res;
	modport source (output valid, output status, output read_value, output count,
		output empty_res, input ready);
	modport sink (input valid, input status, input read_value, input count,
		input empty_res, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/ple_cell.sv
// One list cell: holds an entry and shifts with its neighbors.
`default_nettype none
module ple_cell (
	input  wire logic                           clk,
	input  wire logic [ple_pkg::IDX_W-1:0]      idx,
	input  wire ple_pkg::ple_cmd_t              cmd,
	input  wire logic [ple_pkg::DATA_WIDTH-1:0] left_data,
	input  wire logic [ple_pkg::DATA_WIDTH-1:0] right_data,
	output logic      [ple_pkg::DATA_WIDTH-1:0] data,
	output logic      [ple_pkg::DATA_WIDTH-1:0] rd_part
);
	import ple_pkg::*;

	logic [DATA_WIDTH-1:0] data_q;
	logic                  hit;
	logic                  above;

	assign hit   = (idx == cmd.p0);
	assign above = (idx > cmd.p0);

	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_INS: begin
				if (hit) begin
					data_q <= cmd.data;
				end else if (above) begin
					data_q <= left_data;
				end
			end
			CELL_REM: begin
				// close the gap: take the entry from the right
				if (hit || above) begin
					data_q <= right_data;
				end
			end
			CELL_SET: begin
				if (hit) begin
					data_q <= cmd.data;
				end
			end
			default: begin
			end
		endcase
	end

	assign data    = data_q;
	assign rd_part = ((cmd.op == CELL_GET) && hit) ? data_q : '0;
endmodule
`default_nettype wire

FILE: hw/rtl/ple_ctrl.sv
// Controller: checks positions, keeps the entry count, drives the cell row.
`default_nettype none
`include "assert_macros.svh"
module ple_ctrl (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         accept,
	input  wire logic [ple_pkg::MODE_W-1:0]   mode,
	input  wire logic [ple_pkg::POS_W-1:0]    position,
	input  wire logic [ple_pkg::VAL_W-1:0]    value,
	output ple_pkg::ple_cmd_t                 cmd,
	output ple_pkg::ple_info_t                info
);
	import ple_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;
	logic [CMP_W-1:0] pos_w;
	logic [CMP_W-1:0] cnt_w;
	logic             in_rng;
	logic             ins_rng;
	logic             full;
	ple_op_t          op;
	logic [STATUS_W-1:0] status;

	assign pos_w   = CMP_W'(position);
	assign cnt_w   = CMP_W'(count_q);
	assign in_rng  = (pos_w != '0) && (pos_w <= cnt_w);
	assign ins_rng = (pos_w != '0) && (pos_w <= cnt_w + CMP_W'(1));
	assign full    = (count_q == CNT_W'(CAPACITY));

	always_comb begin
		op        = CELL_HOLD;
		status    = ST_BADPOS;
		count_nxt = count_q;
		case (mode)
			MODE_INSERT: begin
				if (ins_rng) begin
					if (full) begin
						status = ST_FULL;
					end else begin
						op        = CELL_INS;
						status    = ST_OK;
						count_nxt = count_q + CNT_W'(1);
					end
				end
			end
			MODE_REMOVE: begin
				if (in_rng) begin
					op        = CELL_REM;
					status    = ST_OK;
					count_nxt = count_q - CNT_W'(1);
				end
			end
			MODE_GET: begin
				if (in_rng) begin
					op     = CELL_GET;
					status = ST_OK;
				end
			end
			MODE_SET: begin
				if (in_rng) begin
					op     = CELL_SET;
					status = ST_OK;
				end
			end
			MODE_CLEAR: begin
				status    = ST_OK;
				count_nxt = '0;
			end
			default: begin
			end
		endcase
	end

	assign cmd.op     = accept ? op : CELL_HOLD;
	assign cmd.p0     = IDX_W'(position - POS_W'(1));
	assign cmd.data   = DATA_WIDTH'(value);
	assign info.status = status;
	assign info.count  = count_nxt;
	assign info.empty  = (count_nxt == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_nxt;
		end
	end

	`PLE_ASSERT(a_count_cap, count_q <= CNT_W'(CAPACITY), "entry count above capacity")
	`PLE_ASSERT_NEXT(a_count_hold, !accept, $stable(count_q), "count moved without a transfer")
	`PLE_ASSERT_NEXT(a_ins_grow, accept && (op == CELL_INS),
		count_q == $past(count_q) + CNT_W'(1), "insert did not grow the count")
	`PLE_ASSERT_IMPLY(a_full_status, status == ST_FULL, full && (mode == MODE_INSERT),
		"full status on a list with room")
endmodule
`default_nettype wire

FILE: hw/rtl/positional_list_engine_core.sv
// Top level: positional list engine built from a row of shifting cells.
// The result of a command is registered and valid in the cycle after its transfer.
// Throughput: one command per cycle; the whole cell row shifts on the clock edge of the transfer.
// Commands stall only while a finished result waits in the output register.
// Reset clears the entry count and the output valid; entry cells are not reset.
`default_nettype none
module positional_list_engine_core (
	input  wire logic clk,
	input  wire logic arst_n,
	ple_cmd_if.sink   cmd,
	ple_res_if.source res
);
	import ple_pkg::*;

	logic                  accept;
	ple_cmd_t              cell_cmd;
	ple_info_t             info;
	logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
	logic [DATA_WIDTH-1:0] rd_part [CAPACITY];
	logic [DATA_WIDTH-1:0] rd_any;

	logic                res_valid_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [VAL_W-1:0]    res_value_q;
	logic [COUNT_W-1:0]  res_count_q;
	logic                res_empty_q;

	assign cmd.ready = !res_valid_q || res.ready;
	assign accept    = cmd.valid && cmd.ready;

	ple_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.mode     (cmd.mode),
		.position (cmd.position),
		.value    (cmd.value),
		.cmd      (cell_cmd),
		.info     (info)
	);

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_d;
		logic [DATA_WIDTH-1:0] right_d;
		if (g == 0) begin : g_first
			assign left_d = cell_data[g];
		end else begin : g_left
			assign left_d = cell_data[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign right_d = cell_data[g];
		end else begin : g_right
			assign right_d = cell_data[g+1];
		end
		ple_cell u_cell (
			.clk        (clk),
			.idx        (IDX_W'(g)),
			.cmd        (cell_cmd),
			.left_data  (left_d),
			.right_data (right_d),
			.data       (cell_data[g]),
			.rd_part    (rd_part[g])
		);
	end

	// at most one cell answers a get; merge the answers
	always_comb begin
		rd_any = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_any = rd_any | rd_part[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_status_q <= info.status;
			res_value_q  <= VAL_W'(rd_any);
			res_count_q  <= COUNT_W'(info.count);
			res_empty_q  <= info.empty;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.status     = res_status_q;
	assign res.read_value = res_value_q;
	assign res.count      = res_count_q;
	assign res.empty_res  = res_empty_q;
endmodule
`default_nettype wire

FILE: tb/tb_positional_list_engine_core.sv
// Self-checking testbench for the positional list engine: directed and random commands.
`default_nettype none
module tb_positional_list_engine_core;
	import ple_pkg::*;

	localparam int RANDOM_ITEMS = 600;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_START   = 150;
	localparam int HOLD_CYCLES  = 300;
	localparam int MAX_POS      = (1 << POS_W) - 1;

	typedef enum int {BIAS_FILL, BIAS_DRAIN, BIAS_MIX} list_bias_e;
	typedef enum int {RX_STREAM, RX_CHOPPY, RX_STALL} rx_style_e;

	// Mirror of the list contents; predicts one result per accepted command.
	class list_scoreboard;
		typedef struct {
			logic [STATUS_W-1:0] status;
			logic [VAL_W-1:0]    read_value;
			logic [COUNT_W-1:0]  count;
			logic                empty_res;
		} list_result_t;

		logic [DATA_WIDTH-1:0] slots [CAPACITY];
		int unsigned           fill;
		list_result_t          pending_results [$];
		int unsigned           errors;
		int unsigned           full_hits;
		int unsigned           badpos_hits;
		int unsigned           peak_fill;
		int unsigned           mode_hits [8];

		function void note_command(input logic [MODE_W-1:0] mode,
			input logic [POS_W-1:0] position, input logic [VAL_W-1:0] value);
			list_result_t r;
			int           p;
			int           i;
			r.status     = ST_BADPOS;
			r.read_value = '0;
			p            = int'(position);
			case (mode)
				MODE_INSERT: begin
					if (p >= 1 && p <= fill + 1) begin
						if (fill >= CAPACITY) begin
							r.status = ST_FULL;
						end else begin
							// shift the tail up one slot, then drop the new entry in
							for (i = fill; i >= p; i--)
								slots[i] = slots[i-1];
							slots[p-1] = value[DATA_WIDTH-1:0];
							fill++;
							r.status = ST_OK;
						end
					end
				end
				MODE_REMOVE: begin
					if (p >= 1 && p <= fill) begin
						for (i = p; i < fill; i++)
							slots[i-1] = slots[i];
						fill--;
						r.status = ST_OK;
					end
				end
				MODE_GET: begin
					if (p >= 1 && p <= fill) begin
						r.read_value = slots[p-1];
						r.status     = ST_OK;
					end
				end
				MODE_SET: begin
					if (p >= 1 && p <= fill) begin
						slots[p-1] = value[DATA_WIDTH-1:0];
						r.status   = ST_OK;
					end
				end
				MODE_CLEAR: begin
					fill     = 0;
					r.status = ST_OK;
				end
				default: ;
			endcase
			r.count     = COUNT_W'(fill);
			r.empty_res = (fill == 0);
			mode_hits[mode]++;
			if (r.status == ST_FULL)
				full_hits++;
			if (r.status == ST_BADPOS)
				badpos_hits++;
			if (fill > peak_fill)
				peak_fill = fill;
			pending_results.push_back(r);
		endfunction

		function void check_result(input logic [STATUS_W-1:0] status,
			input logic [VAL_W-1:0] read_value, input logic [COUNT_W-1:0] count,
			input logic empty_res);
			list_result_t r;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, actual status=%0d read=%h count=%0d empty=%b",
					$time, status, read_value, count, empty_res);
				errors++;
				return;
			end
			r = pending_results.pop_front();
			if (status !== r.status || read_value !== r.read_value || count !== r.count ||
				empty_res !== r.empty_res) begin
				$display("%0t: result mismatch, expected status=%0d read=%h count=%0d empty=%b",
					$time, r.status, r.read_value, r.count, r.empty_res);
				$display("%0t:                  actual   status=%0d read=%h count=%0d empty=%b",
					$time, status, read_value, count, empty_res);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	ple_cmd_if cmd_bus ();
	ple_res_if res_bus ();

	positional_list_engine_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.res    (res_bus)
	);

	list_scoreboard sb;
	int unsigned    burst_left;
	int unsigned    idle_cycles;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Offer one command, first pausing for a random gap (possibly none) when the current burst is used up.
	task automatic issue(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] position,
		input logic [VAL_W-1:0] value);
		int unsigned gap;
		if (burst_left == 0) begin
			gap        = $urandom_range(0, 8);
			burst_left = $urandom_range(1, 40);
			if (gap != 0) begin
				cmd_bus.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		cmd_bus.valid    <= 1'b1;
		cmd_bus.mode     <= mode;
		cmd_bus.position <= position;
		cmd_bus.value    <= value;
		@(posedge clk);
		while (!cmd_bus.ready) @(posedge clk);
		sb.note_command(mode, position, value);
	endtask

	task automatic issue_random(input list_bias_e bias);
		int unsigned         roll;
		int unsigned         hi;
		logic [MODE_W-1:0]   mode;
		logic [POS_W-1:0]    position;
		roll = $urandom_range(0, 99);
		case (bias)
			BIAS_FILL:
				mode = (roll < 70) ? MODE_INSERT : (roll < 75) ? MODE_REMOVE :
					(roll < 86) ? MODE_GET : (roll < 96) ? MODE_SET :
					MODE_W'(MODE_CLEAR + $urandom_range(1, 3));
			BIAS_DRAIN:
				mode = (roll < 10) ? MODE_INSERT : (roll < 70) ? MODE_REMOVE :
					(roll < 82) ? MODE_GET : (roll < 94) ? MODE_SET :
					(roll < 96) ? MODE_CLEAR : MODE_W'(MODE_CLEAR + $urandom_range(1, 3));
			default:
				mode = (roll < 35) ? MODE_INSERT : (roll < 65) ? MODE_REMOVE :
					(roll < 80) ? MODE_GET : (roll < 94) ? MODE_SET :
					(roll < 96) ? MODE_CLEAR : MODE_W'(MODE_CLEAR + $urandom_range(1, 3));
		endcase
		hi = (mode == MODE_INSERT) ? sb.fill + 1 : sb.fill;
		if (mode <= MODE_SET && hi >= 1 && $urandom_range(0, 99) < 85) begin
			position = POS_W'($urandom_range(1, hi));
		end else begin
			case ($urandom_range(0, 3))
				0:       position = '0;
				1:       position = (hi < MAX_POS) ? POS_W'(hi + 1) : POS_W'(MAX_POS);
				default: position = POS_W'($urandom_range(0, MAX_POS));
			endcase
		end
		issue(mode, position, $urandom());
	endtask

	// Receiver: own ready pattern, one long hold-off, and result checking.
	initial begin
		rx_style_e   style;
		int unsigned run_left;
		int unsigned cyc;
		res_bus.ready = 1'b0;
		style         = RX_STREAM;
		run_left      = 0;
		cyc           = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (res_bus.valid && res_bus.ready)
				sb.check_result(res_bus.status, res_bus.read_value, res_bus.count,
					res_bus.empty_res);
			cyc++;
			if (run_left == 0) begin
				case ($urandom_range(0, 2))
					0: begin style = RX_STREAM; run_left = $urandom_range(10, 60); end
					1: begin style = RX_CHOPPY; run_left = $urandom_range(10, 40); end
					default: begin style = RX_STALL; run_left = $urandom_range(1, 6); end
				endcase
			end
			run_left--;
			if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES)
				res_bus.ready <= 1'b0;
			else if (style == RX_STREAM)
				res_bus.ready <= 1'b1;
			else if (style == RX_CHOPPY)
				res_bus.ready <= 1'($urandom_range(0, 1));
			else
				res_bus.ready <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		list_bias_e  bias;
		int unsigned random_sent;
		int unsigned steps;
		int unsigned extra;
		int unsigned seg_len;
		sb               = new();
		burst_left       = 0;
		idle_cycles      = 0;
		arst_n           = 1'b0;
		cmd_bus.valid    = 1'b0;
		cmd_bus.mode     = MODE_INSERT;
		cmd_bus.position = '0;
		cmd_bus.value    = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty-list rejects, edge positions, all modes, clear
		issue(MODE_GET,    7'd1,   32'h0000_0000);
		issue(MODE_REMOVE, 7'd1,   32'h0000_0000);
		issue(MODE_SET,    7'd1,   32'h1111_1111);
		issue(MODE_INSERT, 7'd0,   32'h2222_2222);
		issue(MODE_INSERT, 7'd2,   32'h3333_3333);
		issue(MODE_INSERT, 7'd1,   32'hFFFF_FFFF);
		issue(MODE_INSERT, 7'd1,   32'h0000_0000);
		issue(MODE_INSERT, 7'd3,   32'hA5A5_A5A5);
		issue(MODE_INSERT, 7'd2,   32'h5A5A_5A5A);
		issue(MODE_GET,    7'd1,   32'h0000_0000);
		issue(MODE_GET,    7'd4,   32'h0000_0000);
		issue(MODE_GET,    7'd5,   32'h0000_0000);
		issue(MODE_SET,    7'd4,   32'h1234_5678);
		issue(MODE_GET,    7'd4,   32'h0000_0000);
		issue(MODE_REMOVE, 7'd5,   32'h0000_0000);
		issue(MODE_REMOVE, 7'd1,   32'h0000_0000);
		issue(MODE_GET,    7'd1,   32'h0000_0000);
		issue(MODE_CLEAR + 3'd1, 7'd1, 32'h0000_0000);
		issue(MODE_CLEAR + 3'd2, 7'd2, 32'h0000_0000);
		issue(MODE_CLEAR + 3'd3, 7'd127, 32'hFFFF_FFFF);
		issue(MODE_GET,    7'd127, 32'h0000_0000);
		issue(MODE_CLEAR,  7'd0,   32'h0000_0000);
		issue(MODE_CLEAR,  7'd127, 32'h0000_0000);
		issue(MODE_INSERT, 7'd1,   32'hDEAD_BEEF);
		issue(MODE_GET,    7'd1,   32'h0000_0000);

		// random: start with a fill segment aimed at capacity, then randomly chosen biased segments
		random_sent = 0;
		bias        = BIAS_FILL;
		while (random_sent < RANDOM_ITEMS) begin
			if (bias == BIAS_FILL) begin
				steps = 0;
				extra = 0;
				while (extra < 6 && steps < 250 && random_sent + steps < RANDOM_ITEMS) begin
					issue_random(BIAS_FILL);
					steps++;
					if (sb.fill == CAPACITY)
						extra++;
				end
				random_sent += steps;
			end else begin
				seg_len = $urandom_range(30, 90);
				if (seg_len > RANDOM_ITEMS - random_sent)
					seg_len = RANDOM_ITEMS - random_sent;
				repeat (seg_len) issue_random(bias);
				random_sent += seg_len;
			end
			case ($urandom_range(0, 3))
				0:       bias = BIAS_FILL;
				1:       bias = BIAS_DRAIN;
				default: bias = BIAS_MIX;
			endcase
		end
		cmd_bus.valid <= 1'b0;

		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered insert/remove/get/set/clear/undefined: %0d/%0d/%0d/%0d/%0d/%0d",
			sb.mode_hits[MODE_INSERT], sb.mode_hits[MODE_REMOVE], sb.mode_hits[MODE_GET],
			sb.mode_hits[MODE_SET], sb.mode_hits[MODE_CLEAR],
			sb.mode_hits[5] + sb.mode_hits[6] + sb.mode_hits[7]);
		$display("Peak fill %0d of %0d, %0d full rejects, %0d bad positions, %0d errors",
			sb.peak_fill, CAPACITY, sb.full_hits, sb.badpos_hits, sb.errors);
		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
`default_nettype wire

FILE: sim.f
+incdir+hw/rtl
hw/rtl/ple_pkg.sv
hw/rtl/ple_cmd_if.sv
hw/rtl/ple_res_if.sv
hw/rtl/ple_cell.sv
hw/rtl/ple_ctrl.sv
hw/rtl/positional_list_engine_core.sv
tb/tb_positional_list_engine_core.sv
